// ===== hw/rtl/rb85_pkg.sv =====
package rb85_pkg;

    // digits per group and the base
    localparam int unsigned DIGITS = 5;
    localparam logic [6:0] BASE = 7'd85;

    // exact reciprocal for a 32-bit value divided by 85: q = (w * DIV85_MAGIC) >> DIV85_SHIFT
    localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
    localparam int unsigned DIV85_SHIFT = 38;
    localparam int unsigned DIV85_QW = 26;

    // exact reciprocal for a 13-bit value divided by 85
    localparam logic [13:0] MOD85_MAGIC = 14'd12337;
    localparam int unsigned MOD85_SHIFT = 20;

    // ascii anchors of the alphabet
    localparam logic [6:0] CHR_ZERO = 7'd48;
    localparam logic [6:0] CHR_LOWER_A = 7'd97;
    localparam logic [6:0] CHR_UPPER_A = 7'd65;

    // running shift resync after a step write
    typedef enum logic [1:0] {
        SYNC_IDLE = 2'd0,
        SYNC_MOD  = 2'd1,
        SYNC_MUL  = 2'd2
    } sync_state_t;

    // a closed group of four bytes, big-endian and zero padded
    typedef struct packed {
        logic [31:0] word;
        logic        closes;
    } grp_word_t;

    // five base-85 digits, most significant in slot 0
    typedef struct packed {
        logic [DIGITS-1:0][6:0] digits;
        logic                   closes;
    } grp_digits_t;

    // base-85 index to alphabet character
    function automatic logic [6:0] z85_char(input logic [6:0] idx);
        logic [6:0] c;
        if (idx < 7'd10)
        begin
            c = CHR_ZERO + idx;
        end
        else if (idx < 7'd36)
        begin
            c = CHR_LOWER_A + idx - 7'd10;
        end
        else if (idx < 7'd62)
        begin
            c = CHR_UPPER_A + idx - 7'd36;
        end
        else
        begin
            case (idx)
                7'd62: c = 7'd46;   // .
                7'd63: c = 7'd45;   // -
                7'd64: c = 7'd58;   // :
                7'd65: c = 7'd43;   // +
                7'd66: c = 7'd61;   // =
                7'd67: c = 7'd94;   // ^
                7'd68: c = 7'd33;   // !
                7'd69: c = 7'd47;   // /
                7'd70: c = 7'd42;   // *
                7'd71: c = 7'd63;   // ?
                7'd72: c = 7'd38;   // &
                7'd73: c = 7'd60;   // <
                7'd74: c = 7'd62;   // >
                7'd75: c = 7'd40;   // (
                7'd76: c = 7'd41;   // )
                7'd77: c = 7'd91;   // [
                7'd78: c = 7'd93;   // ]
                7'd79: c = 7'd123;  // {
                7'd80: c = 7'd125;  // }
                7'd81: c = 7'd64;   // @
                7'd82: c = 7'd37;   // %
                7'd83: c = 7'd36;   // $
                default: c = 7'd35; // #
            endcase
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/rb85_front.sv =====
module rb85_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                final_req,
    input  logic                q_full,
    output logic                push,
    output rb85_pkg::grp_word_t push_data
);
    import rb85_pkg::*;

    logic [23:0] gw_reg, gw_next;
    logic [1:0]  held_reg, held_next;
    logic        accept;
    logic        close_grp;
    logic [31:0] padded;

    // take a byte whenever the queue has room
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign close_grp = (held_reg == 2'd3) || final_req;

    // big-endian packing with zero padding on the right
    always_comb
    begin
        case (held_reg)
            2'd0:    padded = {data_byte, 24'h0};
            2'd1:    padded = {gw_reg[7:0], data_byte, 16'h0};
            2'd2:    padded = {gw_reg[15:0], data_byte, 8'h0};
            default: padded = {gw_reg[23:0], data_byte};
        endcase
    end

    // open group bookkeeping
    always_comb
    begin
        gw_next   = gw_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (close_grp)
            begin
                gw_next   = 24'h0;
                held_next = 2'd0;
            end
            else
            begin
                gw_next   = {gw_reg[15:0], data_byte};
                held_next = held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= 24'h0;
            held_reg <= 2'd0;
        end
        else
        begin
            gw_reg   <= gw_next;
            held_reg <= held_next;
        end
    end

    // closed group goes to the queue
    assign push             = accept && close_grp;
    assign push_data.word   = padded;
    assign push_data.closes = final_req;

endmodule

// ===== hw/rtl/rb85_queue.sv =====
module rb85_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rb85_pkg::grp_word_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output rb85_pkg::grp_word_t head
);
    import rb85_pkg::*;

    grp_word_t   ent_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rb85_divider.sv =====
module rb85_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  rb85_pkg::grp_word_t   head,
    output logic                  pop,
    input  logic                  take,
    output logic                  done,
    output rb85_pkg::grp_digits_t grp_out
);
    import rb85_pkg::*;

    localparam logic [2:0] LAST_CNT = 3'd7;

    logic                   busy_reg, busy_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [31:0]            w_reg;
    logic [DIV85_QW-1:0]    prod_reg;
    logic [DIGITS-1:0][6:0] digit_reg;
    logic                   closes_reg;

    logic                   load;
    logic                   finish;
    logic [31:0]            w_src;
    logic [63:0]            mul_full;
    logic [DIV85_QW-1:0]    mul_q;
    logic [31:0]            q85;
    logic [31:0]            rem;
    logic [2:0]             dig_idx;

    // start a group when idle and the digit slot is free or being taken
    assign load   = head_valid && !busy_reg && (!done_reg || take);
    assign pop    = load;
    assign finish = busy_reg && (cnt_reg == LAST_CNT);

    // shared reciprocal multiplier, quotient by 85
    assign w_src    = load ? head.word : w_reg;
    assign mul_full = 64'(w_src) * 64'(DIV85_MAGIC);
    assign mul_q    = mul_full[DIV85_SHIFT +: DIV85_QW];

    // remainder from the registered quotient
    assign q85 = 32'({prod_reg, 6'b0}) + 32'({prod_reg, 4'b0})
               + 32'({prod_reg, 2'b0}) + 32'(prod_reg);
    assign rem = w_reg - q85;

    // odd counts write the digits from least significant upward
    assign dig_idx = 3'd4 - {1'b0, cnt_reg[2:1]};

    // sequencer: load, then four multiply / remainder pairs
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (take)
        begin
            done_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (finish)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_reg      <= head.word;
            prod_reg   <= mul_q;
            closes_reg <= head.closes;
        end
        else if (busy_reg)
        begin
            if (cnt_reg[0])
            begin
                w_reg <= 32'(prod_reg);
                // last pair also leaves the top digit as the quotient
                if (finish)
                begin
                    digit_reg[1:0] <= {rem[6:0], prod_reg[6:0]};
                end
                else
                begin
                    digit_reg[dig_idx] <= rem[6:0];
                end
            end
            else
            begin
                prod_reg <= mul_q;
            end
        end
    end

    assign done           = done_reg;
    assign grp_out.digits = digit_reg;
    assign grp_out.closes = closes_reg;

endmodule

// ===== hw/rtl/rb85_emitter.sv =====
module rb85_emitter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [6:0]            cfg_wr_data,
    input  logic                  done,
    input  rb85_pkg::grp_digits_t grp_in,
    output logic                  take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            char_code,
    output logic                  group_last,
    output logic                  stream_end
);
    import rb85_pkg::*;

    localparam logic [2:0] LAST_IDX  = 3'(DIGITS - 1);

    logic [6:0]  step_reg, step_next;
    logic [6:0]  offset_reg, offset_next;
    logic [6:0]  shift_reg, shift_next;
    sync_state_t sync_reg, sync_next;
    logic [12:0] sprod_reg;
    logic        active_reg, active_next;
    logic [2:0]  idx_reg, idx_next;
    grp_digits_t grp_reg;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  char_reg;
    logic        glast_reg;
    logic        send_reg;

    logic        out_free;
    logic        can_emit;
    logic        last_char;
    logic [6:0]  digit;
    logic [7:0]  wrapped;
    logic [6:0]  rot_idx;
    logic [7:0]  shift_sum;
    logic [26:0] mod_full;
    logic [6:0]  mod_q;
    logic [12:0] mod_r;

    assign out_free  = !out_valid_reg || !out_stall;
    assign can_emit  = active_reg && (sync_reg == SYNC_IDLE) && out_free;
    assign last_char = (idx_reg == LAST_IDX);
    assign take      = done && (!active_reg || (can_emit && last_char));

    // rotate the digit back by the running shift
    assign digit   = grp_reg.digits[idx_reg];
    assign wrapped = {1'b0, digit} + {1'b0, BASE} - {1'b0, shift_reg};
    assign rot_idx = (digit >= shift_reg) ? (digit - shift_reg) : wrapped[6:0];

    // running shift advances by one step per beat
    assign shift_sum = {1'b0, shift_reg} + {1'b0, step_reg};

    // step * offset mod 85 after a step change
    assign mod_full = 27'(sprod_reg) * 27'(MOD85_MAGIC);
    assign mod_q    = mod_full[MOD85_SHIFT +: 7];
    assign mod_r    = sprod_reg - (13'({mod_q, 6'b0}) + 13'({mod_q, 4'b0})
                    + 13'({mod_q, 2'b0}) + 13'(mod_q));

    // rotation state and resync after a step write
    always_comb
    begin
        step_next   = step_reg;
        offset_next = offset_reg;
        shift_next  = shift_reg;
        sync_next   = sync_reg;
        if (sync_reg == SYNC_MUL)
        begin
            sync_next = SYNC_MOD;
        end
        else if (sync_reg == SYNC_MOD)
        begin
            shift_next = mod_r[6:0];
            sync_next  = SYNC_IDLE;
        end
        if (can_emit)
        begin
            if (last_char && grp_reg.closes)
            begin
                offset_next = 7'd0;
                shift_next  = 7'd0;
            end
            else
            begin
                offset_next = (offset_reg == BASE - 7'd1) ? 7'd0 : offset_reg + 7'd1;
                shift_next  = (shift_sum >= {1'b0, BASE}) ? 7'(shift_sum - {1'b0, BASE})
                                                          : shift_sum[6:0];
            end
        end
        if (cfg_wr_en)
        begin
            step_next = (cfg_wr_data >= BASE) ? cfg_wr_data - BASE : cfg_wr_data;
            sync_next = SYNC_MUL;
        end
    end

    // group sequencing and output register control
    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (can_emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = last_char ? 3'd0 : idx_reg + 3'd1;
            if (last_char)
            begin
                active_next = 1'b0;
            end
        end
        if (take)
        begin
            active_next = 1'b1;
            idx_next    = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 7'd0;
            offset_reg    <= 7'd0;
            shift_reg     <= 7'd0;
            sync_reg      <= SYNC_IDLE;
            active_reg    <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            offset_reg    <= offset_next;
            shift_reg     <= shift_next;
            sync_reg      <= sync_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sync_reg == SYNC_MUL)
        begin
            sprod_reg <= 13'(step_reg) * 13'(offset_reg);
        end
        if (take)
        begin
            grp_reg <= grp_in;
        end
        if (can_emit)
        begin
            char_reg  <= z85_char(rot_idx);
            glast_reg <= last_char;
            send_reg  <= last_char && grp_reg.closes;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_code  = char_reg;
    assign group_last = glast_reg;
    assign stream_end = send_reg;

endmodule

// ===== hw/rtl/rotating_base85_encoder_unit.sv =====
// Rotating base-85 encoder. Bytes come in on the input channel (in_valid,
// in_stall, data_byte, final_req), one per beat; characters leave on the
// output channel (out_valid, out_stall, char_code, group_last, stream_end).
// Every four bytes, or fewer when final_req closes the stream, become five
// Z85 characters, each shifted back by rotation_step times the number of
// characters already sent in the stream. cfg_wr_en / cfg_wr_data set the
// step; values above 84 are taken modulo 85, and the new step is in force
// once the running shift has been resynced through SYNC_MUL and SYNC_MOD.
// The group that a closing beat completes passes through the queue, the
// digit unit and the emitter's output register. The digit unit uses the
// shared 32-bit reciprocal multiplier to split a word into digits over four
// multiply / remainder pairs, and starts no new group until the last is done.
// A two-entry queue sits between the byte packer and the digit unit;
// in_stall is high while it is full. When the receiver holds out_stall the
// output register keeps its beat, the emitter and digit unit wait behind
// it, and bytes keep coming in until the queue fills.
// Reset clears the open group, the rotation count and the step to zero.
module rotating_base85_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] char_code,
    output logic       group_last,
    output logic       stream_end
);
    import rb85_pkg::*;

    logic        q_full;
    logic        push;
    grp_word_t   push_data;
    logic        pop;
    logic        head_valid;
    grp_word_t   head;
    logic        take;
    logic        done;
    grp_digits_t grp;

    // byte packer
    rb85_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .final_req (final_req),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // group queue
    rb85_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // word to base-85 digits
    rb85_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .take       (take),
        .done       (done),
        .grp_out    (grp)
    );

    // rotation, alphabet and output register
    rb85_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .grp_in      (grp),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .group_last  (group_last),
        .stream_end  (stream_end)
    );

endmodule

// ===== tb/sv/tb_rotating_base85_encoder_unit.sv =====
`timescale 1ns / 100ps

module tb_rotating_base85_encoder_unit;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;

    // one output character as it should appear on the result channel
    typedef struct packed {
        logic [6:0] code;
        logic       grp_end;
        logic       strm_end;
    } z85_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [6:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       final_req;
    logic       out_valid;
    logic       out_stall;
    logic [6:0] char_code;
    logic       group_last;
    logic       stream_end;

    // encoder state mirrored on the testbench side
    string      z85_set = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
    logic [6:0] step_now;
    logic [31:0] grp_word;
    logic [1:0] grp_held;
    logic [6:0] rot_count;
    z85_beat_t  pending_chars[$];

    // idling knobs
    int         tx_gap_max = 6;
    int         rx_gap_max = 6;
    int         hold_len = 0;
    logic       hold_token = 1'b0;

    // bookkeeping
    int         err_count = 0;
    int         bytes_sent = 0;
    int         chars_checked = 0;
    int         streams_closed = 0;
    int         step_writes = 0;
    int         stalled_edges = 0;
    int         cycle_count = 0;

    rotating_base85_encoder_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .final_req   (final_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .group_last  (group_last),
        .stream_end  (stream_end)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rotating_base85_encoder_unit regression: fail");
            $finish;
        end
    end

    // expected characters for one accepted byte
    task automatic z85_predict_byte(input logic [7:0] b, input logic fin);
        int unsigned w;
        int unsigned dig [5];
        int unsigned shift;
        int unsigned idx;
        logic [2:0]  cnt;
        byte         ch;
        z85_beat_t   beat;
        grp_word = {grp_word[23:0], b};
        cnt = {1'b0, grp_held} + 3'd1;
        if (cnt < 3'd4 && !fin)
        begin
            grp_held = cnt[1:0];
        end
        else
        begin
            // zero pad a short closing group
            while (cnt < 3'd4)
            begin
                grp_word = grp_word << 8;
                cnt = cnt + 3'd1;
            end
            w = grp_word;
            for (int i = 4; i >= 0; i--)
            begin
                dig[i] = w % 85;
                w = w / 85;
            end
            for (int i = 0; i < 5; i++)
            begin
                shift = (int'(step_now) * int'(rot_count)) % 85;
                idx = (dig[i] + 85 - shift) % 85;
                ch = z85_set[idx];
                beat.code = ch[6:0];
                beat.grp_end = (i == 4);
                beat.strm_end = (i == 4) && fin;
                pending_chars = {pending_chars, beat};
                rot_count = (rot_count + 7'd1) % 7'd85;
            end
            grp_word = '0;
            grp_held = '0;
            if (fin)
            begin
                rot_count = '0;
                streams_closed++;
            end
        end
    endtask

    // one input beat, with a random lead-in gap
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        final_req <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            stalled_edges++;
            @(posedge clk);
        end
        bytes_sent++;
        z85_predict_byte(b, fin);
    endtask

    // stop offering and let every expected character come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // step register write, only while idle
    task automatic write_step(input logic [6:0] val);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_now = val % 7'd85;
        step_writes++;
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // output side stall: random per beat, plus a long hold on request
    initial
    begin
        int   stall_left;
        int   hold_left;
        logic hold_seen;
        stall_left = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = hold_len;
            end
            if (out_valid === 1'b1 && !out_stall)
                stall_left = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // compare each accepted character with the oldest expectation
    always @(posedge clk)
    begin
        z85_beat_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected character, expected none got %0d",
                         $time, char_code);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (char_code !== want.code)
                begin
                    err_count++;
                    $display("%0t: char_code expected %0d got %0d",
                             $time, want.code, char_code);
                end
                if (group_last !== want.grp_end)
                begin
                    err_count++;
                    $display("%0t: group_last expected %0b got %0b",
                             $time, want.grp_end, group_last);
                end
                if (stream_end !== want.strm_end)
                begin
                    err_count++;
                    $display("%0t: stream_end expected %0b got %0b",
                             $time, want.strm_end, stream_end);
                end
            end
        end
    end

    // zero and all-ones words, then closing groups of every length, step 0
    task automatic test_reset_groups();
        write_step(7'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'ha5, 1'b1);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hc3, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7e, 1'b1);
    endtask

    // step change while a partial group is held, sender paused until drained
    task automatic test_step_mid_stream();
        write_step(7'd84);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9a, 1'b0);
        send_byte(8'hbc, 1'b0);
        wait_idle();
        write_step(7'd3);
        send_byte(8'hde, 1'b0);
        send_byte(8'hf0, 1'b1);
    endtask

    // long output hold while bytes keep coming, so the input side backs up
    task automatic test_output_hold();
        write_step(7'd127);
        tx_gap_max = 0;
        rx_gap_max <= 0;
        hold_len <= HOLD_CYCLES;
        hold_token <= ~hold_token;
        for (int i = 0; i < 48; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        for (int i = 0; i < 4; i++)
            send_byte(pick_byte(), i == 3);
    endtask

    // random streams under changing steps and idling patterns
    task automatic test_random_streams();
        logic [6:0] step_list [4];
        int         len;
        int         stream_no;
        int         sent;
        step_list = '{7'd84, 7'd85, 7'd1, 7'd127};
        stream_no = 0;
        sent = 0;
        while (sent < 400)
        begin
            if (stream_no % 3 == 0)
                write_step(stream_no < 12 ? step_list[stream_no / 3]
                                          : 7'($urandom_range(0, 127)));
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            rx_gap_max <= ($urandom_range(0, 3) == 0) ? 0 : 6;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 110)
                                              : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                // occasional step change in the middle of a stream
                if (i == len / 2 && len > 4 && $urandom_range(0, 5) == 0)
                    write_step(7'($urandom_range(0, 127)));
                send_byte(pick_byte(), i == len - 1);
            end
            sent += len;
            stream_no++;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        data_byte   = '0;
        final_req   = 1'b0;
        step_now    = '0;
        grp_word    = '0;
        grp_held    = '0;
        rot_count   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_groups();
        test_step_mid_stream();
        test_output_hold();
        test_random_streams();

        wait_idle();
        if (pending_chars.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d characters never arrived", $time, pending_chars.size());
        end
        $display("encoded %0d bytes in %0d streams, %0d characters checked, %0d step writes",
                 bytes_sent, streams_closed, chars_checked, step_writes);
        $display("input side held off on %0d edges", stalled_edges);
        if (err_count == 0)
            $display("rotating_base85_encoder_unit regression: pass");
        else
            $display("rotating_base85_encoder_unit regression: fail");
        $finish;
    end

endmodule
